FILE: hdl/memory_map_byte_access_unit_macros.svh
// Assertion helpers shared by the memory map unit.
`ifndef MEMORY_MAP_BYTE_ACCESS_UNIT_MACROS_SVH
`define MEMORY_MAP_BYTE_ACCESS_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define MMBA_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mmba assertion failed");

// Next-cycle implication, disabled while reset is high.
`define MMBA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mmba assertion failed");

`endif

FILE: hdl/mmba_pkg.sv
package mmba_pkg;

   localparam int INSTR_ADDR_BITS = 16;
   localparam int DATA_ADDR_BITS  = 16;
   localparam int CLR_BITS        = (INSTR_ADDR_BITS > DATA_ADDR_BITS) ?
                                    INSTR_ADDR_BITS : DATA_ADDR_BITS;
   localparam int LEN_BITS        = INSTR_ADDR_BITS + 1;
   localparam int OFF_BITS        = 26;

   localparam int QUEUE_DEPTH     = 2;
   localparam int QUEUE_PTR_BITS  = 1;
   localparam int COUNT_BITS      = 2;

   typedef logic [LEN_BITS-1:0]        len_type;
   typedef logic [OFF_BITS-1:0]        off_type;
   typedef logic [CLR_BITS-1:0]        clr_addr_type;
   typedef logic [INSTR_ADDR_BITS-1:0] instr_addr_type;
   typedef logic [DATA_ADDR_BITS-1:0]  data_addr_type;
   typedef logic [COUNT_BITS-1:0]      count_type;
   typedef logic [QUEUE_PTR_BITS-1:0]  qptr_type;

   localparam len_type INSTR_SIZE = len_type'(1) << INSTR_ADDR_BITS;

   localparam logic [31:0] INSTR_BASE  = 32'h1000_0000;
   localparam logic [31:0] INSTR_LIMIT = 32'h1100_0000;
   localparam logic [31:0] DATA_BASE   = 32'h2000_0000;
   localparam logic [31:0] DATA_LIMIT  = 32'h2400_0000;
   localparam logic [31:0] GETC_BASE   = 32'h3000_0000;
   localparam logic [31:0] PUTC_BASE   = 32'h3000_0004;
   localparam logic [31:0] PUTC_LIMIT  = 32'h3000_0008;
   localparam logic [7:0]  FILL_BYTE   = 8'hFF;

   typedef enum logic [2:0] {
      CMD_READ       = 3'd0,
      CMD_WRITE      = 3'd1,
      CMD_LOAD       = 3'd2,
      CMD_GETC_FILL  = 3'd3,
      CMD_PUTC_FLUSH = 3'd4
   } cmd_type;

   typedef enum logic [3:0] {
      ACT_FAULT,
      ACT_READ_INSTR,
      ACT_READ_DATA,
      ACT_READ_GETC,
      ACT_WRITE_DATA,
      ACT_WRITE_PUTC,
      ACT_LOAD,
      ACT_GETC_FILL,
      ACT_PUTC_FLUSH
   } action_type;

   typedef enum logic [1:0] {
      SRC_REG,
      SRC_INSTR,
      SRC_DATA
   } src_type;

   typedef struct packed {
      action_type action;
      off_type    offset;
      logic       in_store;
      logic [7:0] data_byte;
      logic       end_of_input;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } push_type;

   typedef struct packed {
      src_type    src;
      logic [7:0] rd_byte;
      logic       status;
      logic       putc_valid;
      logic [7:0] putc_byte;
   } exec_type;

endpackage

FILE: hdl/mmba_front.sv
module mmba_front (
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [2:0]          req_cmd,
   input  logic [31:0]         req_address,
   input  logic [7:0]          req_data_byte,
   input  logic                req_end_of_input,
   input  logic                queue_full,
   input  logic                clearing,
   output mmba_pkg::push_type  push
);

   logic                 is_instr;
   logic                 is_data;
   logic                 is_getc;
   logic                 is_putc;
   logic                 load_ok;
   mmba_pkg::off_type    offset;
   mmba_pkg::action_type action;

   assign is_instr = (req_address >= mmba_pkg::INSTR_BASE) &&
                     (req_address <  mmba_pkg::INSTR_LIMIT);
   assign is_data  = (req_address >= mmba_pkg::DATA_BASE) &&
                     (req_address <  mmba_pkg::DATA_LIMIT);
   assign is_getc  = (req_address >= mmba_pkg::GETC_BASE) &&
                     (req_address <  mmba_pkg::PUTC_BASE);
   assign is_putc  = (req_address >= mmba_pkg::PUTC_BASE) &&
                     (req_address <  mmba_pkg::PUTC_LIMIT);
   assign load_ok  = (req_address >> mmba_pkg::INSTR_ADDR_BITS) ==
                     (mmba_pkg::INSTR_BASE >> mmba_pkg::INSTR_ADDR_BITS);

   // region bases are aligned, so the low address bits are the offset
   assign offset = req_address[mmba_pkg::OFF_BITS-1:0];

   always_comb begin
      unique case (mmba_pkg::cmd_type'(req_cmd))
         mmba_pkg::CMD_READ: begin
            if (is_instr)     action = mmba_pkg::ACT_READ_INSTR;
            else if (is_data) action = mmba_pkg::ACT_READ_DATA;
            else if (is_getc) action = mmba_pkg::ACT_READ_GETC;
            else              action = mmba_pkg::ACT_FAULT;
         end
         mmba_pkg::CMD_WRITE: begin
            if (is_data)      action = mmba_pkg::ACT_WRITE_DATA;
            else if (is_putc) action = mmba_pkg::ACT_WRITE_PUTC;
            else              action = mmba_pkg::ACT_FAULT;
         end
         mmba_pkg::CMD_LOAD: begin
            action = load_ok ? mmba_pkg::ACT_LOAD : mmba_pkg::ACT_FAULT;
         end
         mmba_pkg::CMD_GETC_FILL:  action = mmba_pkg::ACT_GETC_FILL;
         mmba_pkg::CMD_PUTC_FLUSH: action = mmba_pkg::ACT_PUTC_FLUSH;
         default:                  action = mmba_pkg::ACT_FAULT;
      endcase
   end

   assign req_ready = !queue_full && !clearing;

   always_comb begin
      push.valid              = req_valid && req_ready;
      push.entry.action       = action;
      push.entry.offset       = offset;
      push.entry.in_store     = (offset >> mmba_pkg::DATA_ADDR_BITS) == '0;
      push.entry.data_byte    = req_data_byte;
      push.entry.end_of_input = req_end_of_input;
   end

endmodule

FILE: hdl/mmba_queue.sv
`include "memory_map_byte_access_unit_macros.svh"

module mmba_queue (
   input  logic                clock,
   input  logic                reset,
   input  mmba_pkg::push_type  push,
   output logic                full,
   output mmba_pkg::push_type  head,
   input  logic                pop
);

   mmba_pkg::entry_type  entries_ff [mmba_pkg::QUEUE_DEPTH];
   mmba_pkg::qptr_type   wr_ptr_ff, wr_ptr_in;
   mmba_pkg::qptr_type   rd_ptr_ff, rd_ptr_in;
   mmba_pkg::count_type  count_ff, count_in;
   logic                 do_pop;

   assign full       = count_ff == mmba_pkg::count_type'(mmba_pkg::QUEUE_DEPTH);
   assign head.valid = count_ff != '0;
   assign head.entry = entries_ff[rd_ptr_ff];
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = push.valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid && !do_pop) count_in = count_ff + 1'b1;
      if (!push.valid && do_pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) entries_ff[wr_ptr_ff] <= push.entry;
   end

   `MMBA_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= mmba_pkg::count_type'(mmba_pkg::QUEUE_DEPTH))
   `MMBA_ASSERT_SAME(a_no_push_when_full, clock, reset, full, !push.valid)
   `MMBA_ASSERT_NEXT(a_pop_shrinks, clock, reset, do_pop && !push.valid, count_ff == mmba_pkg::count_type'($past(count_ff) - 1'b1))

endmodule

FILE: hdl/mmba_back.sv
`include "memory_map_byte_access_unit_macros.svh"

module mmba_back (
   input  logic                clock,
   input  logic                reset,
   input  mmba_pkg::push_type  head,
   output logic                pop,
   output logic                clearing,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_read_byte,
   output logic                rsp_status,
   output logic                rsp_putc_valid,
   output logic [7:0]          rsp_putc_byte
);

   logic [7:0] instr_mem [2**mmba_pkg::INSTR_ADDR_BITS];
   logic [7:0] data_mem  [2**mmba_pkg::DATA_ADDR_BITS];

   logic                     clearing_ff, clearing_in;
   mmba_pkg::clr_addr_type   clr_addr_ff, clr_addr_in;
   mmba_pkg::len_type        instr_length_ff, instr_length_in;
   logic [3:0][7:0]          getc_window_ff, getc_window_in;
   logic [3:0][7:0]          putc_window_ff, putc_window_in;
   logic                     exec_valid_ff, exec_valid_in;
   mmba_pkg::exec_type       exec_ff, exec_in;
   logic [7:0]               instr_rdata_ff;
   logic [7:0]               data_rdata_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [7:0]               rsp_read_byte_ff;
   logic                     rsp_status_ff;
   logic                     rsp_putc_valid_ff;
   logic [7:0]               rsp_putc_byte_ff;

   logic                     exec_advance;
   logic                     instr_we;
   mmba_pkg::instr_addr_type instr_waddr;
   logic [7:0]               instr_wdata;
   logic                     data_we;
   mmba_pkg::data_addr_type  data_waddr;
   logic [7:0]               data_wdata;
   mmba_pkg::len_type        load_len;
   logic                     instr_hit;
   logic [1:0]               win_idx;
   logic [7:0]               exec_byte;

   assign clearing     = clearing_ff;
   assign exec_advance = exec_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign pop          = head.valid && !clearing_ff && (!exec_valid_ff || exec_advance);

   assign win_idx   = head.entry.offset[1:0];
   assign load_len  = mmba_pkg::len_type'(head.entry.offset[mmba_pkg::INSTR_ADDR_BITS-1:0])
                      + mmba_pkg::len_type'(1);
   assign instr_hit = head.entry.offset < mmba_pkg::off_type'(instr_length_ff);

   // sweep both stores to zero after reset, one address per cycle
   always_comb begin
      clr_addr_in = clr_addr_ff;
      clearing_in = clearing_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == '1) clearing_in = 1'b0;
      end
   end

   always_comb begin
      instr_we        = 1'b0;
      instr_waddr     = head.entry.offset[mmba_pkg::INSTR_ADDR_BITS-1:0];
      instr_wdata     = head.entry.data_byte;
      data_we         = 1'b0;
      data_waddr      = head.entry.offset[mmba_pkg::DATA_ADDR_BITS-1:0];
      data_wdata      = head.entry.data_byte;
      instr_length_in = instr_length_ff;
      getc_window_in  = getc_window_ff;
      putc_window_in  = putc_window_ff;
      exec_in.src        = mmba_pkg::SRC_REG;
      exec_in.rd_byte    = '0;
      exec_in.status     = 1'b0;
      exec_in.putc_valid = 1'b0;
      exec_in.putc_byte  = '0;

      if (clearing_ff) begin
         instr_we    = 1'b1;
         instr_waddr = clr_addr_ff[mmba_pkg::INSTR_ADDR_BITS-1:0];
         instr_wdata = '0;
         data_we     = 1'b1;
         data_waddr  = clr_addr_ff[mmba_pkg::DATA_ADDR_BITS-1:0];
         data_wdata  = '0;
      end else if (pop) begin
         unique case (head.entry.action)
            mmba_pkg::ACT_READ_INSTR: begin
               if (instr_hit) exec_in.src = mmba_pkg::SRC_INSTR;
            end
            mmba_pkg::ACT_READ_DATA: begin
               if (head.entry.in_store) exec_in.src = mmba_pkg::SRC_DATA;
            end
            mmba_pkg::ACT_READ_GETC: begin
               exec_in.rd_byte = getc_window_ff[win_idx];
            end
            mmba_pkg::ACT_WRITE_DATA: begin
               // drop writes above the store, no fault
               data_we = head.entry.in_store;
            end
            mmba_pkg::ACT_WRITE_PUTC: begin
               putc_window_in[win_idx] = head.entry.data_byte;
            end
            mmba_pkg::ACT_LOAD: begin
               instr_we = 1'b1;
               if (load_len > instr_length_ff) instr_length_in = load_len;
            end
            mmba_pkg::ACT_GETC_FILL: begin
               if (head.entry.end_of_input) begin
                  getc_window_in = {4{mmba_pkg::FILL_BYTE}};
               end else begin
                  getc_window_in = '0;
                  getc_window_in[3] = head.entry.data_byte;
               end
            end
            mmba_pkg::ACT_PUTC_FLUSH: begin
               exec_in.putc_valid = 1'b1;
               exec_in.putc_byte  = putc_window_ff[3];
               getc_window_in     = '0;
               putc_window_in     = '0;
            end
            default: begin
               exec_in.status = 1'b1;
            end
         endcase
      end
   end

   always_comb begin
      exec_valid_in = exec_valid_ff;
      if (pop)               exec_valid_in = 1'b1;
      else if (exec_advance) exec_valid_in = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      if (exec_advance)   rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_comb begin
      case (exec_ff.src)
         mmba_pkg::SRC_INSTR: exec_byte = instr_rdata_ff;
         mmba_pkg::SRC_DATA:  exec_byte = data_rdata_ff;
         default:             exec_byte = exec_ff.rd_byte;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff     <= 1'b1;
         clr_addr_ff     <= '0;
         instr_length_ff <= '0;
         getc_window_ff  <= '0;
         putc_window_ff  <= '0;
         exec_valid_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         clearing_ff     <= clearing_in;
         clr_addr_ff     <= clr_addr_in;
         instr_length_ff <= instr_length_in;
         getc_window_ff  <= getc_window_in;
         putc_window_ff  <= putc_window_in;
         exec_valid_ff   <= exec_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) exec_ff <= exec_in;
      if (exec_advance) begin
         rsp_read_byte_ff  <= exec_byte;
         rsp_status_ff     <= exec_ff.status;
         rsp_putc_valid_ff <= exec_ff.putc_valid;
         rsp_putc_byte_ff  <= exec_ff.putc_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (instr_we) instr_mem[instr_waddr] <= instr_wdata;
      if (pop) instr_rdata_ff <= instr_mem[head.entry.offset[mmba_pkg::INSTR_ADDR_BITS-1:0]];
   end

   always_ff @(posedge clock) begin
      if (data_we) data_mem[data_waddr] <= data_wdata;
      if (pop) data_rdata_ff <= data_mem[head.entry.offset[mmba_pkg::DATA_ADDR_BITS-1:0]];
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_byte  = rsp_read_byte_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_putc_valid = rsp_putc_valid_ff;
   assign rsp_putc_byte  = rsp_putc_byte_ff;

   `MMBA_ASSERT_SAME(a_no_pop_while_clearing, clock, reset, clearing_ff, !pop)
   `MMBA_ASSERT_SAME(a_length_in_range, clock, reset, 1'b1, instr_length_ff <= mmba_pkg::INSTR_SIZE)
   `MMBA_ASSERT_NEXT(a_exec_holds_on_stall, clock, reset, exec_valid_ff && rsp_valid_ff && !rsp_ready, exec_valid_ff && rsp_valid_ff)

endmodule

FILE: hdl/memory_map_byte_access_unit.sv
// Byte-wide memory system with instruction, data and console windows.
// Request channel (req_*): one command per request - read byte, write
// byte, load instruction byte, getc fill or putc flush - with a 32-bit
// address, a data byte and an end-of-input flag.
// Response channel (rsp_*): exactly one response per request, in order:
// read byte, status (1 on fault or load out of range), and the putc
// character with its valid flag on a flush.
// Latency: a request accepted at edge N gives its response valid from
// edge N+2 (queue, then memory read stage into the output register).
// Throughput: one request per cycle; the decoder, a two-entry queue and
// the single-port-per-cycle access to each byte store allow this.
// Reset: after reset deasserts, both byte stores are swept to zero one
// address per cycle, 2^16 cycles, while req_ready stays low. The length
// count and both console windows clear at once.
// Stall: when rsp_ready is low the response holds, the execute stage
// holds behind it and the queue fills; req_ready drops when it is full.
module memory_map_byte_access_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_cmd,
   input  logic [31:0] req_address,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_input,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_read_byte,
   output logic        rsp_status,
   output logic        rsp_putc_valid,
   output logic [7:0]  rsp_putc_byte
);

   mmba_pkg::push_type push;
   mmba_pkg::push_type head;
   logic               queue_full;
   logic               clearing;
   logic               pop;

   mmba_front u_front (
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_address      (req_address),
      .req_data_byte    (req_data_byte),
      .req_end_of_input (req_end_of_input),
      .queue_full       (queue_full),
      .clearing         (clearing),
      .push             (push)
   );

   mmba_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .head  (head),
      .pop   (pop)
   );

   mmba_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .pop            (pop),
      .clearing       (clearing),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_read_byte  (rsp_read_byte),
      .rsp_status     (rsp_status),
      .rsp_putc_valid (rsp_putc_valid),
      .rsp_putc_byte  (rsp_putc_byte)
   );

endmodule
